@@ src/la_trig_pkg.sv @@
package la_trig_pkg;

	// Record length; the count width follows from it.
	localparam int CAPTURE_DEPTH = 2048;
	localparam int CNT_W = $clog2(CAPTURE_DEPTH);

	localparam int PIN_W = 8;
	localparam int PERIOD_W = 16;
	localparam int IDX_W = 11;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int MODE_W = 2;

	typedef logic [PIN_W-1:0] pins_t;
	typedef logic [PERIOD_W-1:0] period_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [MODE_W-1:0] mode_t;

	localparam logic REQ_ARM = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	localparam status_t ST_IDLE = 2'd0;
	localparam status_t ST_WAIT = 2'd1;
	localparam status_t ST_SAMPLE = 2'd2;

	localparam mode_t MODE_IDLE = 2'd0;
	localparam mode_t MODE_ARMED = 2'd1;
	localparam mode_t MODE_CAPT = 2'd2;

	localparam cfg_idx_t CFG_LEVEL_MASK = 3'd0;
	localparam cfg_idx_t CFG_LEVEL_VALUE = 3'd1;
	localparam cfg_idx_t CFG_RISE_MASK = 3'd2;
	localparam cfg_idx_t CFG_FALL_MASK = 3'd3;
	localparam cfg_idx_t CFG_SAMPLE_PERIOD = 3'd4;

	typedef struct packed {
		pins_t level_mask;
		pins_t level_value;
		pins_t rise_mask;
		pins_t fall_mask;
		period_t sample_period;
	} cfg_t;

	typedef struct packed {
		logic req_type;
		pins_t pins;
		logic force_req;
	} item_t;

	typedef struct packed {
		status_t status;
		pins_t sample;
		logic [IDX_W-1:0] sample_index;
		logic last;
	} result_t;

endpackage

@@ src/la_trig_ifs.sv @@
interface la_trig_item_if;
	import la_trig_pkg::*;
	logic valid;
	logic ready;
	logic req_type;
	pins_t pins;
	logic force_req;
	modport source (output valid, output req_type, output pins, output force_req,
		input ready);
	modport sink (input valid, input req_type, input pins, input force_req,
		output ready);
endinterface

interface la_trig_result_if;
	import la_trig_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	pins_t sample;
	logic [IDX_W-1:0] sample_index;
	logic last;
	modport source (output valid, output status, output sample, output sample_index,
		output last, input ready);
	modport sink (input valid, input status, input sample, input sample_index,
		input last, output ready);
endinterface

interface la_trig_cfg_if;
	import la_trig_pkg::*;
	logic valid;
	logic ready;
	cfg_idx_t index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/la_trig_regs.sv @@
module la_trig_regs (
	input logic clk,
	input logic arst_n,
	la_trig_cfg_if.sink cfg_port,
	output la_trig_pkg::cfg_t cfg
);
	import la_trig_pkg::*;

	cfg_t cfg_q;

	assign cfg_port.ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_port.valid) begin
			unique case (cfg_port.index)
				CFG_LEVEL_MASK: cfg_q.level_mask <= cfg_port.data[PIN_W-1:0];
				CFG_LEVEL_VALUE: cfg_q.level_value <= cfg_port.data[PIN_W-1:0];
				CFG_RISE_MASK: cfg_q.rise_mask <= cfg_port.data[PIN_W-1:0];
				CFG_FALL_MASK: cfg_q.fall_mask <= cfg_port.data[PIN_W-1:0];
				CFG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_port.data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

@@ src/la_trig_match.sv @@
module la_trig_match (
	input la_trig_pkg::cfg_t cfg,
	input la_trig_pkg::pins_t pins,
	input la_trig_pkg::pins_t prev_pins,
	input logic force_req,
	output logic fire
);
	import la_trig_pkg::*;

	pins_t edges;
	logic level_ok;
	logic edge_mode;

	always_comb begin
		edges = (cfg.rise_mask & pins & ~prev_pins) | (cfg.fall_mask & ~pins & prev_pins);
		// Bits of level_value outside the mask still take part, so such a
		// setting can only be fired by force.
		level_ok = (pins & cfg.level_mask) == cfg.level_value;
		edge_mode = |(cfg.rise_mask | cfg.fall_mask);
		if (force_req) begin
			fire = 1'b1;
		end else if (edge_mode) begin
			fire = (|edges) && level_ok;
		end else begin
			fire = level_ok;
		end
	end

endmodule

@@ src/la_trig_capture.sv @@
module la_trig_capture (
	input logic clk,
	input logic arst_n,
	input la_trig_pkg::cfg_t cfg,
	input la_trig_pkg::item_t item_s1,
	input logic advance,
	input logic fire,
	input logic out_taken,
	output la_trig_pkg::pins_t prev_pins,
	output la_trig_pkg::result_t res_s2,
	output logic vld_s2
);
	import la_trig_pkg::*;

	mode_t mode_q;
	pins_t prev_q;
	cnt_t cnt_q;
	period_t per_q;

	mode_t mode_d;
	cnt_t cnt_d;
	period_t per_d;
	result_t res_d;
	logic lst;

	assign prev_pins = prev_q;

	always_comb begin
		mode_d = mode_q;
		cnt_d = cnt_q;
		per_d = per_q;
		res_d = '0;
		lst = 1'b0;
		if (item_s1.req_type == REQ_ARM) begin
			mode_d = MODE_ARMED;
			cnt_d = '0;
			per_d = '0;
			res_d.status = ST_WAIT;
		end else begin
			res_d.status = ST_IDLE;
			if (mode_q == MODE_ARMED) begin
				res_d.status = ST_WAIT;
				if (fire) begin
					mode_d = MODE_CAPT;
					cnt_d = '0;
					per_d = '0;
				end
			end
			// The triggering tick falls through and is itself sample zero.
			if (mode_d == MODE_CAPT) begin
				if (per_d == '0) begin
					lst = cnt_d == CNT_W'(CAPTURE_DEPTH - 1);
					res_d.status = ST_SAMPLE;
					res_d.sample = item_s1.pins;
					res_d.sample_index = IDX_W'(cnt_d);
					res_d.last = lst;
					per_d = cfg.sample_period;
					if (lst) begin
						mode_d = MODE_IDLE;
						cnt_d = '0;
					end else begin
						cnt_d = cnt_d + 1'b1;
					end
				end else begin
					res_d.status = ST_WAIT;
					per_d = per_d - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			prev_q <= '0;
			cnt_q <= '0;
			per_q <= '0;
			vld_s2 <= 1'b0;
		end else begin
			if (advance) begin
				mode_q <= mode_d;
				cnt_q <= cnt_d;
				per_q <= per_d;
				if (item_s1.req_type == REQ_TICK) begin
					prev_q <= item_s1.pins;
				end
				vld_s2 <= 1'b1;
			end else if (out_taken) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && lst |=> mode_q == MODE_IDLE && cnt_q == '0)
		else $error("record end did not return to idle");

	a_idle_cnt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> cnt_q == '0)
		else $error("sample count not clear while idle");

	a_armed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_ARMED |-> cnt_q == '0 && per_q == '0)
		else $error("counters not clear while armed");

	a_arm_answer: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.req_type == REQ_ARM |=> res_s2.status == ST_WAIT
		&& mode_q == MODE_ARMED)
		else $error("arm beat not answered as waiting");

endmodule

@@ src/logic_analyzer_trigger_capture_top.sv @@
// Eight-channel trigger and capture engine. Every input beat (an arm request or one
// tick of probe levels) yields exactly one result beat, and a new input beat can be
// taken in every clock cycle while the result side is not stalled: the design is one
// input register followed by one result register, with the trigger compare and the
// capture counters between them, and a beat moves from the input register on to the
// result register once the result side is free. After an arm the engine waits for a
// level match, a qualified edge or a forced trigger, then reports one sample every
// sample_period+1 ticks, 2048 in all, marking the last. Configuration writes are
// taken in any cycle but should only be issued while no beat is in flight.
module logic_analyzer_trigger_capture_top (
	input logic clk,
	input logic arst_n,
	la_trig_item_if.sink item,
	la_trig_result_if.source result,
	la_trig_cfg_if.sink cfg
);
	import la_trig_pkg::*;

	item_t item_s1;
	logic vld_s1;
	logic vld_s2;
	logic advance;
	logic fire;
	cfg_t cfg_val;
	pins_t prev_pins;
	result_t res_s2;

	assign advance = vld_s1 && (!vld_s2 || result.ready);
	assign item.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{req_type: item.req_type, pins: item.pins,
				force_req: item.force_req};
		end
	end

	la_trig_regs u_regs (
		.clk (clk),
		.arst_n (arst_n),
		.cfg_port (cfg),
		.cfg (cfg_val)
	);

	la_trig_match u_match (
		.cfg (cfg_val),
		.pins (item_s1.pins),
		.prev_pins (prev_pins),
		.force_req (item_s1.force_req),
		.fire (fire)
	);

	la_trig_capture u_capture (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg_val),
		.item_s1 (item_s1),
		.advance (advance),
		.fire (fire),
		.out_taken (result.ready),
		.prev_pins (prev_pins),
		.res_s2 (res_s2),
		.vld_s2 (vld_s2)
	);

	assign result.valid = vld_s2;
	assign result.status = res_s2.status;
	assign result.sample = res_s2.sample;
	assign result.sample_index = res_s2.sample_index;
	assign result.last = res_s2.last;

endmodule
